// ----- rtl/mtfk_pkg.sv -----
// Shared sizes, types, result codes and helpers for the move-to-front key cache.
// Depends on nothing; every other file refers to it by scoped names.
package mtfk_pkg;

   localparam int unsigned ENTRIES = 64;
   localparam int unsigned KEY_W   = 32;
   localparam int unsigned SLOT_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);
   localparam int unsigned OUT_SLOT_W = 6;

   typedef logic [KEY_W-1:0]      key_type;
   typedef logic [SLOT_W-1:0]     slot_type;
   typedef logic [CNT_W-1:0]      count_type;
   typedef logic [1:0]            status_type;
   typedef logic [OUT_SLOT_W-1:0] out_slot_type;

   localparam count_type FULL_COUNT = count_type'(ENTRIES);
   localparam slot_type  LAST_POS   = slot_type'(ENTRIES - 1);

   localparam status_type ST_HIT    = 2'd0;
   localparam status_type ST_INSERT = 2'd1;
   localparam status_type ST_EVICT  = 2'd2;
   localparam status_type ST_NOLOAD = 2'd3;

   // Control broadcast from the sequencer to every cell of the chain.
   typedef struct packed {
      key_type   lookup_key;
      count_type count;
      logic      compare_en;
      logic      shift_en;
      slot_type  shift_pos;
   } cell_ctl_type;

   // Slot number as reported on the result port: widened or masked to six bits.
   function automatic out_slot_type slot_out(input slot_type s);
      logic [SLOT_W+OUT_SLOT_W-1:0] w;
      w = {{OUT_SLOT_W{1'b0}}, s};
      return w[OUT_SLOT_W-1:0];
   endfunction

endpackage

// ----- rtl/move_to_front_key_cache.sv -----
// Top level of the move-to-front key cache: sequencer, hit resolution and the cell chain.
// Depends on mtfk_pkg and mtfk_cell.
//
//   channel   ports                                   handshake
//   request   req_key, req_can_load                   start high while busy is low
//   result    rsp_status, rsp_slot, rsp_victim_key    rsp_valid high for one cycle
//
// Each item runs through the sequencer states in order: idle takes the item in, lookup
// has every cell compare its key in parallel, resolve turns the match row into a position,
// slot and status, and update shows the result while the chain shifts its entries back by
// one position up to the hit or insertion point; no new item is taken before idle.
// Reset clears the fill count and the sequencer; the cells hold no live entries until
// they are written, so no clearing pass is needed. The receiver cannot stall: a result
// is shown for exactly one cycle and busy stays high until it has been shown.
module move_to_front_key_cache (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  mtfk_pkg::key_type         req_key,
   input  logic                      req_can_load,
   output logic                      rsp_valid,
   output mtfk_pkg::status_type      rsp_status,
   output mtfk_pkg::out_slot_type    rsp_slot,
   output mtfk_pkg::key_type         rsp_victim_key
);

   // One-hot sequencer states.
   typedef enum logic [3:0] {
      S_IDLE    = 4'b0001,
      S_LOOKUP  = 4'b0010,
      S_RESOLVE = 4'b0100,
      S_UPDATE  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // Accepted item.
   mtfk_pkg::key_type   key_ff, key_in;
   logic                can_load_ff, can_load_in;

   // Number of live entries; positions below it are occupied.
   mtfk_pkg::count_type count_ff, count_in;

   // Decision taken in the resolve cycle and applied in the update cycle.
   mtfk_pkg::key_type   front_key_ff, front_key_in;
   mtfk_pkg::slot_type  front_slot_ff, front_slot_in;
   mtfk_pkg::slot_type  pos_ff, pos_in;
   logic                shift_ff, shift_in;
   logic                grow_ff, grow_in;

   // Result registers.
   logic                 rsp_valid_ff, rsp_valid_in;
   mtfk_pkg::status_type rsp_status_ff, rsp_status_in;
   mtfk_pkg::out_slot_type rsp_slot_ff, rsp_slot_in;
   mtfk_pkg::key_type    rsp_victim_ff, rsp_victim_in;

   // Chain wiring.
   mtfk_pkg::cell_ctl_type ctl;
   mtfk_pkg::key_type      cell_key  [mtfk_pkg::ENTRIES];
   mtfk_pkg::slot_type     cell_slot [mtfk_pkg::ENTRIES];
   logic [mtfk_pkg::ENTRIES-1:0] match_vec;

   // Resolve logic.
   logic               hit;
   logic               full;
   mtfk_pkg::key_type  hit_key;
   mtfk_pkg::slot_type hit_slot;
   mtfk_pkg::slot_type hit_pos;

   assign ctl.lookup_key = key_ff;
   assign ctl.count      = count_ff;
   assign ctl.compare_en = (state_ff == S_LOOKUP);
   assign ctl.shift_en   = (state_ff == S_UPDATE) && shift_ff;
   assign ctl.shift_pos  = pos_ff;

   // The chain: position 0 is the most recent entry. During an update every position up
   // to the shift point takes its upstream neighbour's contents, and position 0 takes the
   // entry that is being brought to the front.
   for (genvar i = 0; i < mtfk_pkg::ENTRIES; i++) begin : g_cell
      mtfk_pkg::key_type  up_key;
      mtfk_pkg::slot_type up_slot;

      if (i == 0) begin : g_head
         assign up_key  = front_key_ff;
         assign up_slot = front_slot_ff;
      end else begin : g_body
         assign up_key  = cell_key[i-1];
         assign up_slot = cell_slot[i-1];
      end

      mtfk_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .my_pos     (mtfk_pkg::slot_type'(i)),
         .ctl        (ctl),
         .prev_key   (up_key),
         .prev_slot  (up_slot),
         .cell_key   (cell_key[i]),
         .cell_slot  (cell_slot[i]),
         .cell_match (match_vec[i])
      );
   end

   // Keys are never duplicated, so at most one cell matches and the matching cell's
   // contents and position can be gathered by a plain OR over the row.
   always_comb begin
      hit_key  = '0;
      hit_slot = '0;
      hit_pos  = '0;
      for (int i = 0; i < mtfk_pkg::ENTRIES; i++) begin
         if (match_vec[i]) begin
            hit_key  = hit_key  | cell_key[i];
            hit_slot = hit_slot | cell_slot[i];
            hit_pos  = hit_pos  | mtfk_pkg::slot_type'(i);
         end
      end
   end

   assign hit  = |match_vec;
   assign full = (count_ff == mtfk_pkg::FULL_COUNT);

   always_comb begin
      state_in      = state_ff;
      key_in        = key_ff;
      can_load_in   = can_load_ff;
      count_in      = count_ff;
      front_key_in  = front_key_ff;
      front_slot_in = front_slot_ff;
      pos_in        = pos_ff;
      shift_in      = shift_ff;
      grow_in       = grow_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_victim_in = rsp_victim_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               key_in      = req_key;
               can_load_in = req_can_load;
               state_in    = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            state_in = S_RESOLVE;
         end
         S_RESOLVE: begin
            rsp_valid_in  = 1'b1;
            rsp_victim_in = '0;
            front_key_in  = key_ff;
            grow_in       = 1'b0;
            if (hit) begin
               // Hit: move the matching entry to the front.
               rsp_status_in = mtfk_pkg::ST_HIT;
               rsp_slot_in   = mtfk_pkg::slot_out(hit_slot);
               front_key_in  = hit_key;
               front_slot_in = hit_slot;
               pos_in        = hit_pos;
               shift_in      = 1'b1;
            end else if (!can_load_ff) begin
               // Miss that may not be loaded: nothing changes.
               rsp_status_in = mtfk_pkg::ST_NOLOAD;
               rsp_slot_in   = '0;
               shift_in      = 1'b0;
            end else if (!full) begin
               // Insert into the lowest unused slot, which equals the fill count.
               rsp_status_in = mtfk_pkg::ST_INSERT;
               rsp_slot_in   = mtfk_pkg::slot_out(mtfk_pkg::slot_type'(count_ff));
               front_slot_in = mtfk_pkg::slot_type'(count_ff);
               pos_in        = mtfk_pkg::slot_type'(count_ff);
               shift_in      = 1'b1;
               grow_in       = 1'b1;
            end else begin
               // Full: reuse the least recent entry's slot and report its key.
               rsp_status_in = mtfk_pkg::ST_EVICT;
               rsp_slot_in   = mtfk_pkg::slot_out(cell_slot[mtfk_pkg::ENTRIES-1]);
               rsp_victim_in = cell_key[mtfk_pkg::ENTRIES-1];
               front_slot_in = cell_slot[mtfk_pkg::ENTRIES-1];
               pos_in        = mtfk_pkg::LAST_POS;
               shift_in      = 1'b1;
            end
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            if (grow_ff) begin
               count_in = count_ff + mtfk_pkg::count_type'(1);
            end
            shift_in = 1'b0;
            grow_in  = 1'b0;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         shift_ff     <= 1'b0;
         grow_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         shift_ff     <= shift_in;
         grow_ff      <= grow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      can_load_ff   <= can_load_in;
      front_key_ff  <= front_key_in;
      front_slot_ff <= front_slot_in;
      pos_ff        <= pos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_victim_ff <= rsp_victim_in;
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot       = rsp_slot_ff;
   assign rsp_victim_key = rsp_victim_ff;

   // The result is shown exactly in the update cycle of its item.
   a_rsp_in_update: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff == (state_ff == S_UPDATE))
      else $error("result strobe out of step with the update cycle");

   // At most one cell of the chain may match a key.
   a_single_match: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESOLVE) |-> $onehot0(match_vec))
      else $error("more than one cell matched the looked-up key");

   // An eviction happens only when every position is occupied.
   a_evict_when_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == mtfk_pkg::ST_EVICT)) |-> full)
      else $error("eviction reported while the cache was not full");

   // A hit needs at least one live entry.
   a_hit_needs_entry: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == mtfk_pkg::ST_HIT)) |-> (count_ff != '0))
      else $error("hit reported on an empty cache");

   // The fill count only grows by one, and only at the end of an insertion.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |->
         ($past(state_ff) == S_UPDATE) && ($past(grow_ff)) &&
         (count_ff == $past(count_ff) + mtfk_pkg::count_type'(1)))
      else $error("fill count changed outside an insertion");

endmodule

// ----- rtl/mtfk_cell.sv -----
// One recency position of the move-to-front chain: holds a key and its slot.
// Depends on mtfk_pkg.
module mtfk_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  mtfk_pkg::slot_type    my_pos,
   input  mtfk_pkg::cell_ctl_type ctl,
   input  mtfk_pkg::key_type     prev_key,
   input  mtfk_pkg::slot_type    prev_slot,
   output mtfk_pkg::key_type     cell_key,
   output mtfk_pkg::slot_type    cell_slot,
   output logic                  cell_match
);

   mtfk_pkg::key_type  key_ff,  key_in;
   mtfk_pkg::slot_type slot_ff, slot_in;
   logic               match_ff, match_in;
   logic               occupied;
   logic               take_prev;

   // A position holds a live entry only below the fill count.
   assign occupied  = mtfk_pkg::count_type'(my_pos) < ctl.count;
   assign take_prev = ctl.shift_en && (my_pos <= ctl.shift_pos);

   always_comb begin
      match_in = ctl.compare_en && occupied && (key_ff == ctl.lookup_key);
      key_in   = take_prev ? prev_key  : key_ff;
      slot_in  = take_prev ? prev_slot : slot_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      slot_ff <= slot_in;
   end

   assign cell_key   = key_ff;
   assign cell_slot  = slot_ff;
   assign cell_match = match_ff;

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for move_to_front_key_cache: directed rows, then random phases.
// It depends on mtfk_pkg for the port types and status codes, and on the block itself.
`timescale 1ns / 1ps

module testbench;

   // Watchdog limit.
   localparam int unsigned CYCLE_LIMIT = 200000;

   // One result of a lookup, field by field as the result ports carry it.
   typedef struct packed {
      mtfk_pkg::status_type   status;
      mtfk_pkg::out_slot_type slot;
      mtfk_pkg::key_type      victim;
   } lookup_outcome_type;

   // A directed row. Where pinned is set, the expected result is typed in and
   // replaces the prediction; otherwise the predictor decides.
   typedef struct packed {
      mtfk_pkg::key_type  key;
      logic               can_load;
      logic               pinned;
      lookup_outcome_type outcome;
   } directed_row_type;

   // A random phase: size of the key working set, the sender's idle rate in
   // percent, the number of items, and whether the working set is walked in order.
   typedef struct packed {
      int unsigned pool_size;
      int unsigned idle_pct;
      int unsigned items;
      logic        sweep;
   } phase_type;

   localparam int DIRECTED_ROWS = 18;
   localparam int PHASES        = 7;

   logic                   clock        = 1'b0;
   logic                   reset        = 1'b1;
   logic                   start        = 1'b0;
   logic                   busy;
   mtfk_pkg::key_type      req_key      = '0;
   logic                   req_can_load = 1'b0;
   logic                   rsp_valid;
   mtfk_pkg::status_type   rsp_status;
   mtfk_pkg::out_slot_type rsp_slot;
   mtfk_pkg::key_type      rsp_victim_key;

   move_to_front_key_cache dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_key        (req_key),
      .req_can_load   (req_can_load),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_slot       (rsp_slot),
      .rsp_victim_key (rsp_victim_key)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // ------------------------------------------------------------------
   // Predictor: its own copy of the cache contents and the recency list.
   // ------------------------------------------------------------------
   mtfk_pkg::key_type  cached_keys [mtfk_pkg::ENTRIES];
   mtfk_pkg::slot_type recency     [mtfk_pkg::ENTRIES];
   int unsigned        fill_level = 0;

   // Moves the slot at recency position pos to the front; everything that
   // was in front of it slides back by one position.
   function automatic void promote(input int unsigned pos);
      mtfk_pkg::slot_type s;
      s = recency[pos];
      for (int unsigned p = pos; p > 0; p--)
         recency[p] = recency[p - 1];
      recency[0] = s;
   endfunction

   function automatic lookup_outcome_type predict_lookup(input mtfk_pkg::key_type k,
                                                         input logic load);
      lookup_outcome_type r;
      int unsigned        pos;
      mtfk_pkg::slot_type s;
      bit                 hit;
      r   = '{status: mtfk_pkg::ST_NOLOAD, slot: '0, victim: '0};
      hit = 1'b0;
      // The most recent match wins, although a key is never stored twice.
      for (pos = 0; pos < fill_level; pos++) begin
         s = recency[pos];
         if (cached_keys[s] == k) begin
            hit = 1'b1;
            break;
         end
      end
      if (hit) begin
         r.status = mtfk_pkg::ST_HIT;
         r.slot   = mtfk_pkg::out_slot_type'(s);
         promote(pos);
      end else if (!load) begin
         // Not loadable: nothing changes, slot and victim stay at zero.
         r.status = mtfk_pkg::ST_NOLOAD;
      end else if (fill_level < mtfk_pkg::ENTRIES) begin
         // Still room: the next slot that has never been used takes the key.
         s = mtfk_pkg::slot_type'(fill_level);
         cached_keys[s]      = k;
         recency[fill_level] = s;
         promote(fill_level);
         fill_level++;
         r.status = mtfk_pkg::ST_INSERT;
         r.slot   = mtfk_pkg::out_slot_type'(s);
      end else begin
         // Full: the least recent entry gives up its slot to the new key.
         s = recency[mtfk_pkg::ENTRIES - 1];
         r.status       = mtfk_pkg::ST_EVICT;
         r.slot         = mtfk_pkg::out_slot_type'(s);
         r.victim       = cached_keys[s];
         cached_keys[s] = k;
         promote(mtfk_pkg::ENTRIES - 1);
      end
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Result checking. The store of expected results is filled at the edge
   // that accepts an item and emptied as results come out.
   // ------------------------------------------------------------------
   lookup_outcome_type pending_results [$];
   lookup_outcome_type pinned_outcome = '0;
   logic               row_pinned     = 1'b0;
   int unsigned        failures       = 0;
   int unsigned        cycle_count    = 0;
   lookup_outcome_type seen_result;
   lookup_outcome_type wanted_result;

   task automatic note_mismatch(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      failures++;
      $display("%0t: %s mismatch, expected 0x%08h, got 0x%08h", $time, field, want, got);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid === 1'b1) begin
            seen_result = '{status: rsp_status, slot: rsp_slot, victim: rsp_victim_key};
            if (pending_results.size() == 0) begin
               note_mismatch("unexpected result", '0, seen_result.victim);
            end else begin
               wanted_result = pending_results.pop_front();
               if (seen_result.status !== wanted_result.status)
                  note_mismatch("status", 32'(wanted_result.status),
                                32'(seen_result.status));
               if (seen_result.slot !== wanted_result.slot)
                  note_mismatch("slot", 32'(wanted_result.slot), 32'(seen_result.slot));
               if (seen_result.victim !== wanted_result.victim)
                  note_mismatch("victim_key", wanted_result.victim, seen_result.victim);
            end
         end
         // The predictor advances for every accepted item, pinned or not, so
         // that its state follows the block through the directed rows too.
         if (start && !busy) begin
            wanted_result = predict_lookup(req_key, req_can_load);
            pending_results.push_back(row_pinned ? pinned_outcome : wanted_result);
         end
      end
   end

   // Watchdog: a hung handshake or a lost result ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timed out with %0d results outstanding", $time, pending_results.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus.
   // ------------------------------------------------------------------

   // Presents one item from a falling edge and holds it until the block takes
   // it. Before that the sender may sit idle for a random number of cycles.
   task automatic offer_item(input mtfk_pkg::key_type k, input logic load,
                             input logic pinned, input lookup_outcome_type outcome,
                             input int unsigned idle_pct);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start          = 1'b1;
      req_key        = k;
      req_can_load   = load;
      row_pinned     = pinned;
      pinned_outcome = outcome;
      do
         @(posedge clock);
      while (busy);
   endtask

   // Lowers start and waits until every expected result has come back.
   task automatic drain_results();
      @(negedge clock);
      start = 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
   endtask

   // The directed rows begin on an empty cache. The first eleven rows have
   // results that follow at a glance: a miss that may not load on an empty
   // cache, the extreme keys inserted into the lowest free slots, hits with and
   // without can_load, and keys one bit away from a stored one. The rest mix hits at
   // the front and the back of the recency order with inserts and a miss that may not load, and are predicted.
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{32'h0000_0000, 1'b0, 1'b1, '{mtfk_pkg::ST_NOLOAD, 6'd0, 32'h0}},
      '{32'hFFFF_FFFF, 1'b0, 1'b1, '{mtfk_pkg::ST_NOLOAD, 6'd0, 32'h0}},
      '{32'h0000_0000, 1'b1, 1'b1, '{mtfk_pkg::ST_INSERT, 6'd0, 32'h0}},
      '{32'hFFFF_FFFF, 1'b1, 1'b1, '{mtfk_pkg::ST_INSERT, 6'd1, 32'h0}},
      '{32'h0000_0000, 1'b0, 1'b1, '{mtfk_pkg::ST_HIT,    6'd0, 32'h0}},
      '{32'hFFFF_FFFF, 1'b1, 1'b1, '{mtfk_pkg::ST_HIT,    6'd1, 32'h0}},
      '{32'h8000_0000, 1'b0, 1'b1, '{mtfk_pkg::ST_NOLOAD, 6'd0, 32'h0}},
      '{32'h0000_0001, 1'b1, 1'b1, '{mtfk_pkg::ST_INSERT, 6'd2, 32'h0}},
      '{32'h8000_0000, 1'b1, 1'b1, '{mtfk_pkg::ST_INSERT, 6'd3, 32'h0}},
      '{32'hFFFF_FFFE, 1'b1, 1'b1, '{mtfk_pkg::ST_INSERT, 6'd4, 32'h0}},
      '{32'h7FFF_FFFF, 1'b0, 1'b1, '{mtfk_pkg::ST_NOLOAD, 6'd0, 32'h0}},
      '{32'h0000_0001, 1'b1, 1'b0, '0},
      '{32'h5555_5555, 1'b1, 1'b0, '0},
      '{32'hAAAA_AAAA, 1'b1, 1'b0, '0},
      '{32'h0000_0000, 1'b1, 1'b0, '0},
      '{32'hAAAA_AAAA, 1'b0, 1'b0, '0},
      '{32'h1234_5678, 1'b0, 1'b0, '0},
      '{32'hFFFF_FFFF, 1'b0, 1'b0, '0}
   };

   // Working sets either side of the capacity give a mix of hits, inserts and
   // evictions. The last phase walks 65 keys in order, which in a 64-entry
   // recency cache mostly misses and evicts: the classic worst case.
   phase_type phases [PHASES] = '{
      '{48,  0,  250, 1'b0},
      '{96,  59, 250, 1'b0},
      '{160, 13, 250, 1'b0},
      '{72,  0,  250, 1'b0},
      '{120, 59, 250, 1'b0},
      '{64,  13, 250, 1'b0},
      '{65,  0,  250, 1'b1}
   };

   mtfk_pkg::key_type key_pool [$];

   initial begin
      mtfk_pkg::key_type k;
      logic              load;
      int unsigned       choice;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i])
         offer_item(directed_rows[i].key, directed_rows[i].can_load,
                    directed_rows[i].pinned, directed_rows[i].outcome, 0);
      drain_results();

      foreach (phases[ph]) begin
         key_pool.delete();
         repeat (phases[ph].pool_size)
            key_pool.push_back($urandom);
         for (int unsigned i = 0; i < phases[ph].items; i++) begin
            if (phases[ph].sweep) begin
               k    = key_pool[i % phases[ph].pool_size];
               load = ($urandom_range(99) < 95);
            end else begin
               choice = $urandom_range(99);
               // Mostly keys from the working set; some differ from a working-set key
               // in one bit only, and some are fresh so that the set drifts.
               if (choice < 70)
                  k = key_pool[$urandom_range(phases[ph].pool_size - 1)];
               else if (choice < 82)
                  k = key_pool[$urandom_range(phases[ph].pool_size - 1)]
                      ^ (32'h1 << $urandom_range(31));
               else
                  k = $urandom;
               load = ($urandom_range(99) < 80);
            end
            offer_item(k, load, 1'b0, '0, phases[ph].idle_pct);
         end
         // The sender holds back here until every result of the phase is in.
         drain_results();
      end

      // Nothing more is expected; the extra wait below catches any stray result.
      repeat (8) @(posedge clock);
      if (failures == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
